### rtl/slcp_pkg.sv
// slcp_pkg: shared types and constants for the status LED colour priority block
// used by slcp_ctrl, slcp_dp and status_led_color_priority; no dependencies
package slcp_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_INIT_A,
    S_DIV_A,
    S_INIT_B,
    S_DIV_B,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    CAT_VIOLET,
    CAT_FLASH_DIM,
    CAT_FLASH_BRIGHT,
    CAT_HOTEND,
    CAT_BED,
    CAT_PAUSED,
    CAT_WHITE
  } cat_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic eval;      // run the priority chain, update fan and flash state
    logic div_init;  // load the divider for one ramp
    logic top_b;     // second hotend ramp (blue) instead of the first
    logic div_step;  // one quotient bit
    logic commit;    // deliver the colour if it changed
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic auto_on;
    logic need_ramp;
    logic two_ramps;
    logic div_last;
    logic fin_ok;
  } sts_t;

  localparam int unsigned REG_AUTO     = 0;
  localparam int unsigned REG_HOT_HYST = 1;
  localparam int unsigned REG_BED_HYST = 2;
  localparam int unsigned REG_FLASH_SH = 3;

  localparam logic [6:0] TOP_HOT_G = 7'd96;
  localparam logic [6:0] TOP_HOT_B = 7'd32;
  localparam logic [6:0] TOP_BED   = 7'd64;

  localparam logic [23:0] COL_VIOLET = 24'hFF00FF;
  localparam logic [23:0] COL_DIM    = 24'h40407F;
  localparam logic [23:0] COL_BRIGHT = 24'h4040FF;
  localparam logic [23:0] COL_PAUSED = 24'h20FF20;
  localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;

endpackage

### rtl/status_led_color_priority.sv
// status_led_color_priority: top level, joins the sequencer and the datapath
// depends on slcp_pkg, slcp_ctrl and slcp_dp
//
//  channel  direction  signals                                         handshake
//  in       input      homing paused fan_event hotend_* bed_*          in_valid/in_ready
//  out      output     red green blue                                  out_valid/out_ready
//  cfg      input      cfg_index cfg_data                              cfg_we, no wait
//
// one tick at a time: accept, evaluate, then deliver (manual mode ends after the
// evaluation); a bed ramp adds one 7-step restoring division and a hotend ramp
// two, both done in the shared divider
// synchronous active-low reset: control and config registers to defaults, recorded colour cleared to off
// a changed colour waits in the last step while the output register holds an
// untaken beat; no new tick is taken until it moves on
module status_led_color_priority import slcp_pkg::*; #(
  parameter int TEMP_WIDTH = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_homing,
  input  logic                  in_paused,
  input  logic                  in_fan_event,
  input  logic [TEMP_WIDTH-1:0] in_hotend_target,
  input  logic [TEMP_WIDTH-1:0] in_hotend_now,
  input  logic [TEMP_WIDTH-1:0] in_bed_target,
  input  logic [TEMP_WIDTH-1:0] in_bed_now,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue
);

  cmd_t cmd;
  sts_t sts;

  slcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slcp_dp #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_homing        (in_homing),
    .in_paused        (in_paused),
    .in_fan_event     (in_fan_event),
    .in_hotend_target (in_hotend_target),
    .in_hotend_now    (in_hotend_now),
    .in_bed_target    (in_bed_target),
    .in_bed_now       (in_bed_now),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

endmodule

### rtl/slcp_ctrl.sv
// slcp_ctrl: sequencer for one tick: evaluate, up to two serial ramp divisions,
// then deliver; depends on slcp_pkg
module slcp_ctrl import slcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.auto_on) state_nxt = S_IDLE;
        else if (sts.need_ramp) state_nxt = S_INIT_A;
        else state_nxt = S_FIN;
      end
      S_INIT_A: state_nxt = S_DIV_A;
      S_DIV_A: begin
        if (sts.div_last) state_nxt = sts.two_ramps ? S_INIT_B : S_FIN;
      end
      S_INIT_B: state_nxt = S_DIV_B;
      S_DIV_B: begin
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.fin_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL:   cmd.eval = 1'b1;
      S_INIT_A: cmd.div_init = 1'b1;
      S_DIV_A:  cmd.div_step = 1'b1;
      S_INIT_B: begin
        cmd.div_init = 1'b1;
        cmd.top_b    = 1'b1;
      end
      S_DIV_B:  cmd.div_step = 1'b1;
      S_FIN:    cmd.commit = sts.fin_ok;
      default:  cmd = '0;
    endcase
  end

endmodule

### rtl/slcp_dp.sv
// slcp_dp: datapath with config registers, fan and flash state, shortfall
// ramps on a restoring divider, colour mux and output register; uses slcp_pkg
module slcp_dp import slcp_pkg::*; #(
  parameter int TEMP_WIDTH = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_homing,
  input  logic                  in_paused,
  input  logic                  in_fan_event,
  input  logic [TEMP_WIDTH-1:0] in_hotend_target,
  input  logic [TEMP_WIDTH-1:0] in_hotend_now,
  input  logic [TEMP_WIDTH-1:0] in_bed_target,
  input  logic [TEMP_WIDTH-1:0] in_bed_now,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue
);

  localparam int TW = TEMP_WIDTH;
  localparam int CW = (TW > 11) ? TW : 11;
  localparam int NW = TW + 8;

  // configuration
  logic       auto_r;
  logic [7:0] hot_hyst_r, bed_hyst_r;
  logic [2:0] flash_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r     <= 1'b1;
      hot_hyst_r <= 8'd12;
      bed_hyst_r <= 8'd12;
      flash_sh_r <= 3'd2;
    end else if (cfg_we) begin
      case (32'(cfg_index))
        REG_AUTO:     auto_r     <= cfg_data[0];
        REG_HOT_HYST: hot_hyst_r <= cfg_data;
        REG_BED_HYST: bed_hyst_r <= cfg_data;
        REG_FLASH_SH: flash_sh_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // captured input beat
  logic          homing_r, paused_r, fan_ev_r;
  logic [TW-1:0] ht_r, hn_r, bt_r, bn_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      homing_r <= in_homing;
      paused_r <= in_paused;
      fan_ev_r <= in_fan_event;
      ht_r     <= in_hotend_target;
      hn_r     <= in_hotend_now;
      bt_r     <= in_bed_target;
      bn_r     <= in_bed_now;
    end
  end

  // priority chain
  logic          pend_eff;
  logic [9:0]    cnt_eff;
  logic [TW-1:0] hdiff, bdiff, hot_hyst_x, bed_hyst_x;
  logic          hot_short, bed_short;
  cat_t          cat_nxt;

  assign hot_hyst_x = TW'(hot_hyst_r);
  assign bed_hyst_x = TW'(bed_hyst_r);
  assign hdiff      = ht_r - hn_r;
  assign bdiff      = bt_r - bn_r;
  assign hot_short  = (ht_r >= hn_r) && (hdiff >= hot_hyst_x);
  assign bed_short  = (bt_r >= bn_r) && (bdiff >= bed_hyst_x);

  logic       fan_pend_r;
  logic [9:0] flash_cnt_r;

  assign pend_eff = fan_pend_r | fan_ev_r;
  assign cnt_eff  = pend_eff ? (10'd4 << flash_sh_r) : flash_cnt_r;

  always_comb begin
    if (homing_r) cat_nxt = CAT_VIOLET;
    else if (cnt_eff != 10'd0) cat_nxt = cnt_eff[flash_sh_r] ? CAT_FLASH_DIM : CAT_FLASH_BRIGHT;
    else if (hot_short) cat_nxt = CAT_HOTEND;
    else if (bed_short) cat_nxt = CAT_BED;
    else if (paused_r) cat_nxt = CAT_PAUSED;
    else cat_nxt = CAT_WHITE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_pend_r  <= 1'b0;
      flash_cnt_r <= 10'd0;
    end else if (cmd.eval) begin
      if (!auto_r || homing_r) begin
        fan_pend_r <= pend_eff;
      end else begin
        fan_pend_r  <= 1'b0;
        flash_cnt_r <= (cnt_eff != 10'd0) ? cnt_eff - 10'd1 : cnt_eff;
      end
    end
  end

  // ramp operands
  cat_t          cat_r;
  logic [TW-1:0] e_r;
  logic [10:0]   span_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cat_r <= cat_nxt;
      if (cat_nxt == CAT_HOTEND) begin
        e_r    <= hdiff - hot_hyst_x;
        span_r <= 11'({hot_hyst_r, 2'b00}) + 11'(hot_hyst_r);
      end else begin
        e_r    <= bdiff - bed_hyst_x;
        span_r <= 11'({bed_hyst_r, 1'b0}) + 11'(bed_hyst_r);
      end
    end
  end

  // restoring divider: ceil(e * top / span), quotient fits 7 bits when e < span
  logic [6:0]    top_r, q_r, ramp_a_r, ramp_now;
  logic [NW-1:0] rem_r, prod, div_sh;
  logic [2:0]    cnt_r;
  logic          e_zero, e_big;

  always_comb begin
    case (cat_r)
      CAT_HOTEND: prod = cmd.top_b ? (NW'(e_r) << 5) : ((NW'(e_r) << 6) + (NW'(e_r) << 5));
      default:    prod = NW'(e_r) << 6;
    endcase
  end

  assign div_sh = NW'(span_r) << cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= prod + NW'(span_r) - NW'(1);
      q_r   <= 7'd0;
      cnt_r <= 3'd6;
      if (cat_r == CAT_HOTEND) top_r <= cmd.top_b ? TOP_HOT_B : TOP_HOT_G;
      else top_r <= TOP_BED;
      if (cmd.top_b) ramp_a_r <= ramp_now;
    end else if (cmd.div_step) begin
      if (rem_r >= div_sh) begin
        rem_r     <= rem_r - div_sh;
        q_r[cnt_r] <= 1'b1;
      end
      cnt_r <= cnt_r - 3'd1;
    end
  end

  assign e_zero   = (e_r == '0);
  assign e_big    = (CW'(e_r) >= CW'(span_r));
  assign ramp_now = e_zero ? top_r : (e_big ? 7'd0 : top_r - q_r);

  // colour and delivery
  logic [23:0] color, shown_r;
  logic [7:0]  g_hot;
  logic        out_valid_r, load_out;
  logic [7:0]  red_r, green_r, blue_r;

  assign g_hot = 8'd32 + 8'(ramp_a_r);

  always_comb begin
    case (cat_r)
      CAT_VIOLET:       color = COL_VIOLET;
      CAT_FLASH_DIM:    color = COL_DIM;
      CAT_FLASH_BRIGHT: color = COL_BRIGHT;
      CAT_HOTEND:       color = {8'hFF, g_hot, 8'(ramp_now)};
      CAT_BED:          color = {8'hFF, 8'(ramp_now), 8'(ramp_now)};
      CAT_PAUSED:       color = COL_PAUSED;
      CAT_WHITE:        color = COL_WHITE;
      default:          color = COL_WHITE;
    endcase
  end

  assign load_out = cmd.commit && (color != shown_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= 24'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        shown_r     <= color;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_r   <= color[23:16];
      green_r <= color[15:8];
      blue_r  <= color[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  assign sts.auto_on   = auto_r;
  assign sts.need_ramp = (cat_nxt == CAT_HOTEND) || (cat_nxt == CAT_BED);
  assign sts.two_ramps = (cat_r == CAT_HOTEND);
  assign sts.div_last  = (cnt_r == 3'd0);
  assign sts.fin_ok    = (color == shown_r) || !out_valid_r || out_ready;

  // a delivered beat carries the colour now recorded as shown
  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && ({red_r, green_r, blue_r} == shown_r))
    else $error("output beat differs from shown colour");

  // the flash counter never exceeds its longest reload
  a_flash_max: assert property (@(posedge clk) disable iff (!rst_n)
    flash_cnt_r <= 10'd512)
    else $error("flash counter out of range");

  // manual mode leaves the flash counter alone
  a_manual_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && !auto_r) |=> $stable(flash_cnt_r))
    else $error("flash counter moved in manual mode");

  // an unchanged colour is never delivered again
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (color != shown_r))
    else $error("repeated colour delivered");

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for status_led_color_priority, one initial block runs the tests
// drives update ticks and register writes, predicts every colour change and checks each beat
// depends on slcp_pkg and the status_led_color_priority rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slcp_pkg::*;

  localparam int TW = 11;
  localparam int LAT_PAD = 30;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [23:0] RGB_VIOLET       = 24'hFF00FF;
  localparam logic [23:0] RGB_FLASH_DIM    = 24'h40407F;
  localparam logic [23:0] RGB_FLASH_BRIGHT = 24'h4040FF;
  localparam logic [23:0] RGB_PAUSED       = 24'h20FF20;
  localparam logic [23:0] RGB_WHITE        = 24'hFFFFFF;

  typedef logic [TW-1:0] temp_t;

  typedef struct packed {
    logic  homing;
    logic  paused;
    logic  fan_event;
    temp_t hot_target;
    temp_t hot_now;
    temp_t bed_target;
    temp_t bed_now;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_homing;
  logic in_paused;
  logic in_fan_event;
  temp_t in_hotend_target;
  temp_t in_hotend_now;
  temp_t in_bed_target;
  temp_t in_bed_now;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // predicted block state and register copies
  logic pr_auto = 1'b1;
  logic [7:0] pr_hot_hyst = 8'd12;
  logic [7:0] pr_bed_hyst = 8'd12;
  logic [2:0] pr_flash_sh = 3'd2;
  logic [9:0] flash_left = '0;
  logic fan_latched = 1'b0;
  logic [23:0] lit_colour = '0;
  logic [23:0] colour_due[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  status_led_color_priority #(.TEMP_WIDTH(TW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_homing(in_homing),
    .in_paused(in_paused),
    .in_fan_event(in_fan_event),
    .in_hotend_target(in_hotend_target),
    .in_hotend_now(in_hotend_now),
    .in_bed_target(in_bed_target),
    .in_bed_now(in_bed_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // truncated, clamped linear fade from top at the threshold down to 0 at threshold + span
  function automatic int unsigned graded(int unsigned top, int unsigned over, int unsigned span);
    int unsigned q;
    if (over == 0) return top;
    if (span == 0) return 0;
    q = (over * top + span - 1) / span;
    return (q >= top) ? 0 : top - q;
  endfunction

  task automatic predict_colour(input tick_t t);
    logic [23:0] want;
    int unsigned over;
    int unsigned p;
    fan_latched = fan_latched | t.fan_event;
    if (!pr_auto) return;
    if (t.homing) begin
      want = RGB_VIOLET;
    end else begin
      if (fan_latched) begin
        flash_left = 10'(4 << pr_flash_sh);
        fan_latched = 1'b0;
      end
      if (flash_left != 0) begin
        want = flash_left[pr_flash_sh] ? RGB_FLASH_DIM : RGB_FLASH_BRIGHT;
        flash_left = flash_left - 10'd1;
      end else if (t.hot_target >= t.hot_now &&
                   int'(t.hot_target) - int'(t.hot_now) >= int'(pr_hot_hyst)) begin
        over = t.hot_target - t.hot_now - pr_hot_hyst;
        want = {8'hFF, 8'(32 + graded(96, over, 5 * pr_hot_hyst)),
                8'(graded(32, over, 5 * pr_hot_hyst))};
      end else if (t.bed_target >= t.bed_now &&
                   int'(t.bed_target) - int'(t.bed_now) >= int'(pr_bed_hyst)) begin
        over = t.bed_target - t.bed_now - pr_bed_hyst;
        p = graded(64, over, 3 * pr_bed_hyst);
        want = {8'hFF, 8'(p), 8'(p)};
      end else if (t.paused) begin
        want = RGB_PAUSED;
      end else begin
        want = RGB_WHITE;
      end
    end
    if (want != lit_colour) begin
      lit_colour = want;
      colour_due.push_back(want);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (colour_due.size() == 0) begin
        report_mismatch("colour beat with nothing expected", {out_red, out_green, out_blue}, 0);
      end else begin
        want = colour_due.pop_front();
        if (out_red !== want[23:16]) report_mismatch("red", out_red, want[23:16]);
        if (out_green !== want[15:8]) report_mismatch("green", out_green, want[15:8]);
        if (out_blue !== want[7:0]) report_mismatch("blue", out_blue, want[7:0]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls plus an optional long hold-off counted here
  initial begin
    int unsigned rx_gap;
    rx_gap = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ready = 1'b0;
        rx_gap--;
      end else begin
        out_ready = 1'b1;
        if (!rx_calm) rx_gap = gap_length();
      end
    end
  end

  // valid is left high after the beat so that a following tick can go back to back
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = tx_calm ? 0 : gap_length();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {in_homing, in_paused, in_fan_event, in_hotend_target, in_hotend_now,
     in_bed_target, in_bed_now} = t;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_colour(t);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (colour_due.size() != 0) @(posedge clk);
  endtask

  // a tick may end with no beat, so give the block time to finish before touching registers
  task automatic settle();
    drain();
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = 2'(idx);
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_AUTO:     pr_auto = value[0];
      REG_HOT_HYST: pr_hot_hyst = value;
      REG_BED_HYST: pr_bed_hyst = value;
      REG_FLASH_SH: pr_flash_sh = value[2:0];
      default: ;
    endcase
  endtask

  function automatic tick_t mk(input logic homing, input logic paused, input logic fan,
                               input int unsigned ht, input int unsigned hn,
                               input int unsigned bt, input int unsigned bn);
    tick_t t;
    t.homing = homing;
    t.paused = paused;
    t.fan_event = fan;
    t.hot_target = temp_t'(ht);
    t.hot_now = temp_t'(hn);
    t.bed_target = temp_t'(bt);
    t.bed_now = temp_t'(bn);
    return t;
  endfunction

  // target and reading, mostly around the threshold and its fade
  function automatic void pick_pair(input int unsigned h, input int unsigned mul,
                                    output temp_t tgt, output temp_t cur);
    int unsigned d;
    int unsigned c;
    case ($urandom_range(0, 4))
      0: begin
        tgt = temp_t'($urandom);
        cur = temp_t'($urandom);
      end
      1: begin
        c = $urandom_range(0, (1 << TW) - 1);
        d = $urandom_range(0, 40);
        cur = temp_t'(c);
        tgt = (c >= d) ? temp_t'(c - d) : '0;
      end
      default: begin
        d = $urandom_range(0, mul * h + 2);
        c = $urandom_range(0, (1 << TW) - 1 - d);
        cur = temp_t'(c);
        tgt = temp_t'(c + d);
      end
    endcase
  endfunction

  function automatic tick_t rand_tick(input int unsigned fan_pct);
    tick_t t;
    t.homing = ($urandom_range(0, 11) == 0);
    t.paused = 1'($urandom_range(0, 1));
    t.fan_event = ($urandom_range(0, 99) < fan_pct);
    pick_pair(pr_hot_hyst, 6, t.hot_target, t.hot_now);
    pick_pair(pr_bed_hyst, 4, t.bed_target, t.bed_now);
    return t;
  endfunction

  function automatic logic [7:0] pick_hyst();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(1, 24));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic test_colour_priority();
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 1, 0, 2047, 2047, 0, 0));
    send_tick(mk(1, 1, 0, 2047, 0, 2047, 0));
    // hotend exactly at threshold wins over a bed shortfall
    send_tick(mk(0, 0, 0, 2047, 2035, 2047, 0));
    send_tick(mk(0, 0, 0, 2047, 0, 0, 0));
    send_tick(mk(0, 0, 0, 1000, 960, 0, 0));
    // reading above target never counts as a shortfall
    send_tick(mk(0, 0, 0, 0, 2047, 12, 0));
    send_tick(mk(0, 0, 0, 100, 89, 2047, 0));
  endtask

  task automatic test_fan_flash();
    settle();
    write_reg(REG_FLASH_SH, 8'd0);
    send_tick(mk(0, 0, 1, 0, 0, 0, 0));
    repeat (4) send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    // homing keeps the latch, the flash starts on the first tick after it
    send_tick(mk(1, 0, 1, 0, 0, 0, 0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_manual_mode();
    settle();
    write_reg(REG_AUTO, 8'd0);
    send_tick(mk(0, 0, 1, 0, 0, 0, 0));
    send_tick(mk(1, 1, 0, 2047, 0, 2047, 0));
    settle();
    write_reg(REG_AUTO, 8'd1);
    send_tick(mk(0, 1, 0, 0, 0, 0, 0));
  endtask

  task automatic test_hysteresis_extremes();
    settle();
    write_reg(REG_HOT_HYST, 8'd0);
    write_reg(REG_BED_HYST, 8'd0);
    // empty fade span: full level at zero excess, off beyond
    send_tick(mk(0, 0, 0, 500, 500, 0, 0));
    send_tick(mk(0, 0, 0, 500, 499, 0, 0));
    send_tick(mk(0, 0, 0, 0, 1, 7, 7));
    send_tick(mk(0, 0, 0, 0, 1, 8, 7));
    settle();
    write_reg(REG_HOT_HYST, 8'd255);
    write_reg(REG_BED_HYST, 8'd255);
    send_tick(mk(0, 0, 0, 2047, 1792, 0, 0));
    send_tick(mk(0, 0, 0, 254, 0, 2047, 0));
  endtask

  task automatic test_backpressure();
    int i;
    settle();
    tx_calm = 1'b1;
    rx_hold = 300;
    // homing toggles so every tick changes the colour
    for (i = 0; i < 16; i++) begin
      send_tick(mk(1'(i % 2), 0, 0, 300, 300, 300, 300));
    end
    tx_calm = 1'b0;
    drain();
  endtask

  task automatic test_random_ticks();
    int phase;
    int i;
    int count;
    logic [2:0] shift;
    for (phase = 0; phase < 9; phase++) begin
      settle();
      write_reg(REG_HOT_HYST, pick_hyst());
      write_reg(REG_BED_HYST, pick_hyst());
      shift = (phase == 6) ? 3'd7 : 3'($urandom_range(0, 3));
      write_reg(REG_FLASH_SH, 8'(shift));
      write_reg(REG_AUTO, 8'(phase != 4));
      tx_calm = (phase == 2);
      rx_calm = (phase == 2);
      count = (phase == 4) ? 12 : 42;
      for (i = 0; i < count; i++) begin
        send_tick(rand_tick((shift == 3'd7) ? 1 : 6));
        if ($urandom_range(0, 39) == 0) drain();
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    {in_homing, in_paused, in_fan_event} = '0;
    in_hotend_target = '0;
    in_hotend_now = '0;
    in_bed_target = '0;
    in_bed_now = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_colour_priority();
    test_fan_flash();
    test_manual_mode();
    test_hysteresis_extremes();
    test_backpressure();
    test_random_ticks();
    test_backpressure();
    settle();

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
